[design/wsrm_pkg.sv]
// shared types and constants for the wildcard star regex matcher
// no dependencies; imported by the interfaces, the cell and the top level
package wsrm_pkg;

   localparam int CHAR_W     = 8;
   localparam int LEN_W      = 5;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [LEN_W-1:0] len_type;

   localparam char_type STAR_CHAR = 8'h2A;
   localparam char_type DOT_CHAR  = 8'h2E;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

   // per-item control broadcast to every cell
   typedef struct packed {
      logic     load;
      logic     restart;
      char_type text_char;
   } cell_ctl_type;

   // signals handed from cell k to cell k+1
   typedef struct packed {
      logic carry;
      logic carry_next;
      logic fwd;
   } link_type;

   // per-cell status seen by the top level
   typedef struct packed {
      logic active;
      logic closed;
      logic closed_next;
   } tap_type;

endpackage

[design/wsrm_req_if.sv]
// item channel carrying text bytes into the matcher
// depends on wsrm_pkg
interface wsrm_req_if import wsrm_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     kind;
   char_type text_char;
   logic     final_char;

   modport source (output valid, kind, text_char, final_char, input ready);
   modport sink (input valid, kind, text_char, final_char, output ready);
endinterface

[design/wsrm_rsp_if.sv]
// result channel carrying the match bit out of the matcher
// depends on wsrm_pkg
interface wsrm_rsp_if import wsrm_pkg::*; ();
   logic valid;
   logic ready;
   logic matched;

   modport source (output valid, matched, input ready);
   modport sink (input valid, matched, output ready);
endinterface

[design/wsrm_cell.sv]
// one pattern position of the matcher: holds its active bit, compares its
// pattern char against the text byte and ripples star closure to the right
// depends on wsrm_pkg
module wsrm_cell import wsrm_pkg::*; #(
   parameter int CELL_INDEX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  char_type     pat_char,
   input  len_type      pat_len,
   input  logic         star_in,
   output logic         star_out,
   input  link_type     link_in,
   output link_type     link_out,
   output tap_type      tap
);

   localparam len_type POS       = LEN_W'(CELL_INDEX);
   localparam logic    START_BIT = (CELL_INDEX == 0);

   logic active_ff;
   logic active_in;
   logic in_use;
   logic in_mask;
   logic is_star;
   logic is_elem;
   logic starred;
   logic skip;
   logic closed;
   logic hit;
   logic next_bit;
   logic closed_next;

   always_comb begin
      in_use   = (POS < pat_len);
      in_mask  = (POS <= pat_len);
      is_star  = (pat_char == STAR_CHAR);
      is_elem  = in_use && !is_star;
      starred  = is_elem && star_in;
      skip     = in_use && (is_star || starred);
      star_out = in_use && is_star;

      // closure of the stored set, then one step on the text byte
      closed   = in_mask && (active_ff || link_in.carry);
      hit      = is_elem && closed &&
                 ((pat_char == ctl.text_char) || (pat_char == DOT_CHAR));
      next_bit = (hit && starred) || link_in.fwd;

      // closure of the stepped set, used when the item ends a text
      closed_next = in_mask && (next_bit || link_in.carry_next);

      link_out.carry      = closed && skip;
      link_out.carry_next = closed_next && skip;
      link_out.fwd        = hit && !starred;

      tap.active      = active_ff;
      tap.closed      = closed;
      tap.closed_next = closed_next;
   end

   always_comb begin
      active_in = active_ff;
      if (ctl.restart) begin
         active_in = START_BIT;
      end else if (ctl.load) begin
         active_in = next_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= START_BIT;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

[design/wildcard_star_regex_matcher.sv]
// top level of the wildcard star regex matcher: configuration registers,
// the row of pattern cells and the result register
// depends on wsrm_pkg, wsrm_req_if, wsrm_rsp_if and wsrm_cell
//
// Usage: load the pattern through the csr port (index 0 chars 0..7, index 1
// chars 8..15, index 2 length) while no text is in progress. Stream one text
// byte per req item with kind 0; set final_char on the last one. An empty text
// is sent as a single item with kind 1 and final_char 1. Each final item gives
// one rsp item whose matched bit tells whether the whole text matched.
// Throughput is one item per cycle while rsp is not stalled: every cell
// updates its active bit in the cycle the byte is taken, with star closure
// rippling through the cell row twice in that cycle (before and after the
// step). The result is registered, so it appears on rsp in the cycle after
// the final item is taken. A waiting result blocks input only while rsp.ready
// is low: req.ready drops exactly when a result is held and rsp.ready is low,
// so a stall on rsp backs up into req.
// Reset clears the pattern to length 0, empties the result register and puts
// the cell row back at the start position.
module wildcard_star_regex_matcher import wsrm_pkg::*; #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   wsrm_req_if.sink              req_chan,
   wsrm_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam len_type MAX_LEN = LEN_W'(MAX_PATTERN);
   localparam int      SEL_W   = $clog2(MAX_PATTERN + 1);

   logic [CSR_DATA_W-1:0] pat_low_ff;
   logic [CSR_DATA_W-1:0] pat_high_ff;
   len_type               pat_len_ff;
   logic                  end_ff;
   logic                  end_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  matched_ff;
   logic                  matched_in;

   logic [2*CSR_DATA_W-1:0] pat_word;
   len_type                 len_eff;
   logic                    in_fire;
   logic                    out_fire;
   logic                    at_end;
   cell_ctl_type            ctl;
   link_type                link  [0:MAX_PATTERN];
   logic                    star  [0:MAX_PATTERN];
   tap_type                 taps  [0:MAX_PATTERN-1];
   logic [MAX_PATTERN:0]    closed_vec;
   logic [MAX_PATTERN:0]    closed_next_vec;
   logic [MAX_PATTERN:0]    raw_vec;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PAT_LOW:  pat_low_ff  <= csr_data;
            REG_PAT_HIGH: pat_high_ff <= csr_data;
            REG_PAT_LEN:  pat_len_ff  <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign pat_word = {pat_high_ff, pat_low_ff};
   assign len_eff  = (pat_len_ff > MAX_LEN) ? MAX_LEN : pat_len_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign in_fire        = req_chan.valid && req_chan.ready;
   assign out_fire       = rsp_valid_ff && rsp_chan.ready;

   always_comb begin
      ctl.restart   = in_fire && req_chan.final_char;
      ctl.load      = in_fire && !req_chan.final_char && (req_chan.kind == KIND_CHAR);
      ctl.text_char = req_chan.text_char;
   end

   assign link[0]            = '0;
   assign star[MAX_PATTERN]  = 1'b0;

   for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
      wsrm_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .pat_char (pat_word[g*CHAR_W +: CHAR_W]),
         .pat_len  (len_eff),
         .star_in  (star[g+1]),
         .star_out (star[g]),
         .link_in  (link[g]),
         .link_out (link[g+1]),
         .tap      (taps[g])
      );
      assign closed_vec[g]      = taps[g].closed;
      assign closed_next_vec[g] = taps[g].closed_next;
      assign raw_vec[g]         = taps[g].active;
   end

   // position past the last cell: pattern complete
   assign at_end                       = (len_eff == MAX_LEN);
   assign closed_vec[MAX_PATTERN]      = at_end && (end_ff || link[MAX_PATTERN].carry);
   assign closed_next_vec[MAX_PATTERN] = at_end &&
                                         (link[MAX_PATTERN].fwd || link[MAX_PATTERN].carry_next);
   assign raw_vec[MAX_PATTERN]         = end_ff;

   always_comb begin
      end_in = end_ff;
      if (ctl.restart) begin
         end_in = 1'b0;
      end else if (ctl.load) begin
         end_in = link[MAX_PATTERN].fwd;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !out_fire;
      matched_in   = matched_ff;
      if (ctl.restart) begin
         rsp_valid_in = 1'b1;
         matched_in   = (req_chan.kind == KIND_END) ? closed_vec[len_eff[SEL_W-1:0]]
                                                   : closed_next_vec[len_eff[SEL_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.matched = matched_ff;

   localparam logic [MAX_PATTERN:0] START_SET = (MAX_PATTERN+1)'(1);

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_fire && req_chan.final_char))
      else $error("result raised without a final item");

   a_restart_set: assert property (@(posedge clock) disable iff (reset)
      in_fire && req_chan.final_char |=> raw_vec == START_SET)
      else $error("cell row not back at start after final item");

   a_empty_hold: assert property (@(posedge clock) disable iff (reset)
      in_fire && (req_chan.kind == KIND_END) && !req_chan.final_char |=> $stable(raw_vec))
      else $error("non-final empty end changed the active set");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_valid_ff && !rsp_chan.ready)
      else $error("input stalled without a held result");

endmodule

[sim/tb_wildcard_star_regex_matcher.sv]
// self-checking testbench for the wildcard star regex matcher: streams texts against
// patterns loaded through the csr port and checks every match bit against a local NFA
// depends on wsrm_pkg, wsrm_req_if, wsrm_rsp_if and wildcard_star_regex_matcher
`timescale 1ns / 100ps

module tb_wildcard_star_regex_matcher;
   import wsrm_pkg::*;

   localparam int       MAX_PAT         = 16;
   localparam int       HOLD_OFF_CYCLES = 300;
   localparam int       WATCHDOG_LIMIT  = 4000;
   localparam int       DRAIN_CYCLES    = 4;
   localparam int       MAX_REPORTS     = 10;
   localparam int       PHASE_ITEMS     = 140;
   localparam char_type CH_A            = 8'h61;
   localparam char_type CH_B            = 8'h62;
   localparam char_type CH_C            = 8'h63;

   typedef struct packed {
      logic     kind;
      char_type text_char;
      logic     final_char;
   } text_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   wsrm_req_if req_chan ();
   wsrm_rsp_if rsp_chan ();

   wildcard_star_regex_matcher #(
      .MAX_PATTERN(MAX_PAT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // local copy of the pattern registers and the active position set
   logic [63:0] pat_low;
   logic [63:0] pat_high;
   logic [4:0]  pat_len_reg;
   logic [16:0] nfa_active;

   text_item_type pending_q[$];
   logic          match_bits_q[$];
   char_type      text_buf[$];
   text_item_type drive_item;
   logic          exp_bit;
   logic          exp_rsp;
   logic          has_result;

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic pressure_armed = 1'b0;
   logic pressure_done = 1'b0;
   int   hold_count = 0;
   int   fail_count = 0;
   int   idle_cycles = 0;
   int   phase_items = 0;

   function automatic int eff_len();
      int n;
      n = int'(pat_len_reg);
      return (n > MAX_PAT) ? MAX_PAT : n;
   endfunction

   function automatic char_type pat_char(int k);
      if (k < 8) return pat_low[k*8 +: 8];
      return pat_high[(k-8)*8 +: 8];
   endfunction

   // element k is followed by a star that applies to it
   function automatic logic has_star(int k, int len);
      if (k >= len || pat_char(k) == STAR_CHAR) return 1'b0;
      return (k + 1 < len) && (pat_char(k + 1) == STAR_CHAR);
   endfunction

   function automatic logic [16:0] star_closure(logic [16:0] set, int len);
      logic [17:0] mask;
      mask = (18'd1 << (len + 1)) - 18'd1;
      set = set & mask[16:0];
      for (int k = 0; k < len; k++) begin
         if (set[k] && (pat_char(k) == STAR_CHAR || has_star(k, len))) set[k+1] = 1'b1;
      end
      return set;
   endfunction

   function automatic logic [16:0] step_positions(logic [16:0] set, int len, char_type c);
      logic [16:0] nxt;
      char_type    p;
      nxt = '0;
      for (int k = 0; k < len; k++) begin
         p = pat_char(k);
         if (set[k] && p != STAR_CHAR && (p == c || p == DOT_CHAR)) begin
            if (has_star(k, len)) nxt[k] = 1'b1;
            else nxt[k+1] = 1'b1;
         end
      end
      return nxt;
   endfunction

   // advance the NFA by one item; returns 1 when the item yields a match bit
   function automatic logic predict_match(input text_item_type it, output logic bit_out);
      int          len;
      logic [16:0] cur;
      logic [16:0] nxt;
      len = eff_len();
      cur = star_closure(nfa_active, len);
      bit_out = 1'b0;
      if (it.kind == KIND_END) begin
         if (!it.final_char) return 1'b0;
         bit_out = cur[len];
         nfa_active = 17'd1;
         return 1'b1;
      end
      nxt = step_positions(cur, len, it.text_char);
      if (it.final_char) begin
         nxt = star_closure(nxt, len);
         bit_out = nxt[len];
         nfa_active = 17'd1;
         return 1'b1;
      end
      nfa_active = nxt;
      return 1'b0;
   endfunction

   function automatic char_type rand_text_char();
      case ($urandom_range(0, 5))
         0: return CH_A;
         1: return CH_B;
         2: return CH_C;
         3: return STAR_CHAR;
         4: return DOT_CHAR;
         default: return char_type'($urandom);
      endcase
   endfunction

   function automatic char_type rand_pat_char();
      case ($urandom_range(0, 9))
         0, 1: return CH_A;
         2: return CH_B;
         3: return CH_C;
         4, 5: return DOT_CHAR;
         6, 7: return STAR_CHAR;
         8: return char_type'($urandom);
         default: return CH_B;
      endcase
   endfunction

   // driver: one item offered per cycle unless idling or held by a low req ready
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            has_result = predict_match(drive_item, exp_bit);
            if (has_result) match_bits_q.push_back(exp_bit);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               drive_item = pending_q.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.kind       <= drive_item.kind;
               req_chan.text_char  <= drive_item.text_char;
               req_chan.final_char <= drive_item.final_char;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check match bits and drive rsp ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (match_bits_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected result: matched=%0b", rsp_chan.matched);
            end else begin
               exp_rsp = match_bits_q.pop_front();
               if (rsp_chan.matched !== exp_rsp) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("mismatch: matched expected %0b got %0b", exp_rsp,
                              rsp_chan.matched);
               end
            end
         end
         // long hold-off so the result backs up into the item input
         if (pressure_armed && !pressure_done) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // hold-off length counted in cycles
   always @(posedge clock) begin
      if (reset) begin
         hold_count <= 0;
      end else if (pressure_armed && !pressure_done) begin
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_OFF_CYCLES - 1) pressure_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic push_item(logic kind, char_type c, logic fin);
      text_item_type it;
      it.kind = kind;
      it.text_char = c;
      it.final_char = fin;
      pending_q.push_back(it);
      phase_items++;
   endtask

   task automatic queue_text(logic finish);
      int last;
      last = text_buf.size() - 1;
      if (text_buf.size() == 0) begin
         if (finish) push_item(KIND_END, char_type'($urandom), 1'b1);
      end else begin
         for (int i = 0; i <= last; i++) begin
            // an empty end without final is dropped by the block
            if ($urandom_range(0, 19) == 0) push_item(KIND_END, char_type'($urandom), 1'b0);
            push_item(KIND_CHAR, text_buf[i], finish && (i == last));
         end
      end
   endtask

   task automatic build_matching_text();
      int       k;
      int       len;
      int       reps;
      char_type c;
      text_buf.delete();
      len = eff_len();
      k = 0;
      while (k < len) begin
         c = pat_char(k);
         if (c == STAR_CHAR) begin
            k++;
         end else if (has_star(k, len)) begin
            reps = $urandom_range(0, 3);
            repeat (reps) text_buf.push_back((c == DOT_CHAR) ? rand_text_char() : c);
            k += 2;
         end else begin
            text_buf.push_back((c == DOT_CHAR) ? rand_text_char() : c);
            k++;
         end
      end
   endtask

   task automatic queue_random_text();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         build_matching_text();
         if ($urandom_range(0, 4) == 0) begin
            if (text_buf.size() != 0 && $urandom_range(0, 1) == 1)
               text_buf[$urandom_range(0, text_buf.size() - 1)] = rand_text_char();
            else
               text_buf.push_back(rand_text_char());
         end
      end else if (pick < 80) begin
         text_buf.delete();
         n = $urandom_range(0, 6);
         repeat (n) text_buf.push_back(rand_text_char());
      end else if (pick < 90) begin
         text_buf.delete();
      end else begin
         // truncated well-formed text
         build_matching_text();
         if (text_buf.size() != 0) text_buf.pop_back();
      end
      queue_text(1'b1);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_PAT_LOW:  pat_low = data;
         REG_PAT_HIGH: pat_high = data;
         REG_PAT_LEN:  pat_len_reg = data[4:0];
         default: ;
      endcase
      #1;
   endtask

   task automatic load_pattern(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
      write_csr(REG_PAT_LOW, lo);
      write_csr(REG_PAT_HIGH, hi);
      write_csr(REG_PAT_LEN, CSR_DATA_W'(len));
   endtask

   task automatic wait_idle();
      while (pending_q.size() != 0 || req_chan.valid === 1'b1 || match_bits_q.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      #1;
   endtask

   task automatic run_phase(int n, int sidle, int rstall, logic partial);
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      phase_items = 0;
      while (phase_items < n) queue_random_text();
      // leave a text open so the next pattern picks it up mid-way
      if (partial) begin
         text_buf.delete();
         repeat (2) text_buf.push_back(rand_text_char());
         queue_text(1'b0);
      end
      wait_idle();
   endtask

   initial begin
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  len;
      req_chan.valid = 1'b0;
      req_chan.kind = KIND_CHAR;
      req_chan.text_char = '0;
      req_chan.final_char = 1'b0;
      rsp_chan.ready = 1'b0;
      pat_low = '0;
      pat_high = '0;
      pat_len_reg = '0;
      nfa_active = 17'd1;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // empty pattern after reset
      push_item(KIND_END, 8'h00, 1'b1);
      push_item(KIND_CHAR, CH_A, 1'b1);
      push_item(KIND_END, 8'hFF, 1'b0);
      push_item(KIND_CHAR, 8'h00, 1'b0);
      push_item(KIND_CHAR, STAR_CHAR, 1'b1);
      wait_idle();

      // leading star, a*, b*, doubled star, dot, c
      load_pattern({CH_C, DOT_CHAR, STAR_CHAR, STAR_CHAR, CH_B, STAR_CHAR, CH_A, STAR_CHAR},
                   64'hFFFF_FFFF_FFFF_FFFF, 5'd8);
      push_item(KIND_CHAR, 8'hFF, 1'b0);
      push_item(KIND_CHAR, CH_C, 1'b1);
      push_item(KIND_CHAR, CH_A, 1'b0);
      push_item(KIND_CHAR, CH_A, 1'b0);
      push_item(KIND_CHAR, CH_B, 1'b0);
      push_item(KIND_CHAR, 8'h00, 1'b0);
      push_item(KIND_CHAR, CH_C, 1'b1);
      push_item(KIND_CHAR, CH_B, 1'b0);
      push_item(KIND_CHAR, STAR_CHAR, 1'b0);
      push_item(KIND_CHAR, CH_C, 1'b1);
      push_item(KIND_CHAR, CH_C, 1'b1);
      push_item(KIND_END, 8'h55, 1'b1);
      wait_idle();

      for (int p = 0; p < 10; p++) begin
         for (int k = 0; k < 8; k++) begin
            lo[k*8 +: 8] = rand_pat_char();
            hi[k*8 +: 8] = rand_pat_char();
         end
         case (p % 5)
            0: len = 5'd16;
            1: len = 5'd31;
            2: len = 5'd0;
            3: len = 5'($urandom_range(1, 8));
            default: len = 5'($urandom_range(9, 30));
         endcase
         if (p == 7) hi = '1;
         load_pattern(lo, hi, len);
         case (p % 4)
            0: run_phase(PHASE_ITEMS, 0, 0, p % 3 == 1);
            1: run_phase(PHASE_ITEMS, 69, 0, p % 3 == 1);
            2: run_phase(PHASE_ITEMS, 0, 69, p % 3 == 1);
            default: run_phase(PHASE_ITEMS, 14, 14, p % 3 == 1);
         endcase
      end

      // receiver holds off while items keep coming
      for (int k = 0; k < 8; k++) begin
         lo[k*8 +: 8] = rand_pat_char();
         hi[k*8 +: 8] = char_type'($urandom);
      end
      load_pattern(lo, hi, 5'($urandom_range(2, 6)));
      pressure_armed = 1'b1;
      run_phase(60, 0, 0, 1'b0);

      if (match_bits_q.size() != 0) begin
         fail_count++;
         $display("%0d match bits never arrived", match_bits_q.size());
      end
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
